FILE: rtl/color_window_mask_centroid_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the colour-window mask and centroid block.
// Each macro expands to one labelled concurrent assertion on the rising clock,
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef COLOR_WINDOW_MASK_CENTROID_TOP_DEFINES_SVH
`define COLOR_WINDOW_MASK_CENTROID_TOP_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds in the same cycle.
`define CWMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cwmc assertion failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define CWMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cwmc assertion failed");

`endif

FILE: rtl/cwmc_pkg.sv
// ----------------------------------------------------------------------------
// cwmc_pkg
// Shared widths, limits and types for the colour-window mask and centroid
// block.
// ----------------------------------------------------------------------------
package cwmc_pkg;

    // Field widths fixed by the interface.
    localparam int CH_W    = 8;
    localparam int LINE_W  = 11;
    localparam int HIT_W   = 21;
    localparam int SUM_W   = 30;
    localparam int CENT_W  = 10;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 11;

    // Saturation limits.
    localparam logic [HIT_W-1:0]  HIT_LIMIT      = {HIT_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_LIMIT      = {SUM_W{1'b1}};
    localparam logic [CENT_W-1:0] CENTROID_LIMIT = {CENT_W{1'b1}};
    localparam logic [CH_W-1:0]   FULL_8         = {CH_W{1'b1}};

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_RED_MIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RED_MAX   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GREEN_MIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLUE_MIN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLUE_MAX  = 3'd5;
    localparam logic [IDX_W-1:0] REG_LINE_W    = 3'd6;
    localparam logic [IDX_W-1:0] REG_DIFF_MODE = 3'd7;

    localparam logic [LINE_W-1:0] LINE_W_RESET = 11'd640;

    // Colour window bounds.
    typedef struct packed {
        logic [CH_W-1:0] red_min;
        logic [CH_W-1:0] red_max;
        logic [CH_W-1:0] green_min;
        logic [CH_W-1:0] green_max;
        logic [CH_W-1:0] blue_min;
        logic [CH_W-1:0] blue_max;
    } t_window_cfg;

    // Request into the shared divider.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [HIT_W-1:0] divisor;
    } t_div_req;

    // Response from the shared divider.
    typedef struct packed {
        logic              done;
        logic [CENT_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: rtl/cwmc_pixel.sv
// ----------------------------------------------------------------------------
// cwmc_pixel
// Per-pixel classifier: optional reference subtraction with a zero clamp,
// then an inclusive window test on each colour channel.
// ----------------------------------------------------------------------------
module cwmc_pixel (
    input  logic [cwmc_pkg::CH_W-1:0] i_red,
    input  logic [cwmc_pkg::CH_W-1:0] i_green,
    input  logic [cwmc_pkg::CH_W-1:0] i_blue,
    input  logic [cwmc_pkg::CH_W-1:0] i_ref_red,
    input  logic [cwmc_pkg::CH_W-1:0] i_ref_green,
    input  logic [cwmc_pkg::CH_W-1:0] i_ref_blue,
    input  logic                      i_diff_mode,
    input  cwmc_pkg::t_window_cfg     i_window,
    output logic                      o_hit
);
    import cwmc_pkg::*;

    logic [CH_W-1:0] red_v;
    logic [CH_W-1:0] green_v;
    logic [CH_W-1:0] blue_v;

    // Difference mode: current minus reference, never below zero.
    always_comb begin
        red_v   = i_red;
        green_v = i_green;
        blue_v  = i_blue;
        if (i_diff_mode) begin
            red_v   = (i_red   > i_ref_red)   ? i_red   - i_ref_red   : '0;
            green_v = (i_green > i_ref_green) ? i_green - i_ref_green : '0;
            blue_v  = (i_blue  > i_ref_blue)  ? i_blue  - i_ref_blue  : '0;
        end
    end

    // A window whose minimum is above its maximum matches nothing.
    assign o_hit = (red_v   >= i_window.red_min)   && (red_v   <= i_window.red_max)
                && (green_v >= i_window.green_min) && (green_v <= i_window.green_max)
                && (blue_v  >= i_window.blue_min)  && (blue_v  <= i_window.blue_max);

endmodule

FILE: rtl/cwmc_div.sv
// ----------------------------------------------------------------------------
// cwmc_div
// Shared restoring divider, one quotient bit per cycle, followed by a
// rounding step: nearest with ties to even, clamped to the centroid range.
// ----------------------------------------------------------------------------
module cwmc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cwmc_pkg::t_div_req i_req,
    output cwmc_pkg::t_div_rsp o_rsp
);
    import cwmc_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);
    localparam int REM_W = HIT_W + 1;

    logic             r_busy, n_busy;
    logic             r_round, n_round;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [HIT_W-1:0] r_rem, n_rem;
    logic [SUM_W-1:0] r_quo, n_quo;
    logic [HIT_W-1:0] r_den, n_den;
    logic             r_done, n_done;
    logic [CENT_W-1:0] r_q, n_q;

    logic [REM_W-1:0] trial_in;
    logic [REM_W-1:0] trial;
    logic             fits;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] den_ext;
    logic             round_up;
    logic [SUM_W:0]   q_inc;

    // One restoring step on the shifted partial remainder.
    assign trial_in = {r_rem, r_quo[SUM_W-1]};
    assign den_ext  = {1'b0, r_den};
    assign fits     = trial_in >= den_ext;
    assign trial    = trial_in - den_ext;

    // Rounding on the final remainder: twice the remainder against the divisor.
    assign rem2     = {r_rem, 1'b0};
    assign round_up = (rem2 > den_ext) || ((rem2 == den_ext) && r_quo[0]);
    assign q_inc    = {1'b0, r_quo} + {{SUM_W{1'b0}}, round_up};

    always_comb begin
        n_busy  = r_busy;
        n_round = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        n_done  = 1'b0;
        n_q     = r_q;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = fits ? trial[HIT_W-1:0] : trial_in[HIT_W-1:0];
            n_quo = {r_quo[SUM_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(SUM_W - 1)) begin
                n_busy  = 1'b0;
                n_round = 1'b1;
            end
        end else if (r_round) begin
            n_done = 1'b1;
            n_q    = (q_inc > (SUM_W+1)'(CENTROID_LIMIT)) ? CENTROID_LIMIT
                                                           : q_inc[CENT_W-1:0];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_round <= n_round;
            r_done  <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_q   <= n_q;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    `include "color_window_mask_centroid_top_defines.svh"

    // A new division is only launched while the unit is free.
    `CWMC_ASSERT_IMP(a_div_start_free, i_clk, i_rst_n, i_req.start, !r_busy && !r_round)

endmodule

FILE: rtl/color_window_mask_centroid_top.sv
// ----------------------------------------------------------------------------
// color_window_mask_centroid_top
// Colour-window mask and blob centroid over a raster RGB pixel stream.
//
// Usage: pixels arrive on the input channel (i_valid / o_ready) with an
// optional reference pixel and a frame-end flag. Each transfer yields one
// mask result on the output channel (o_valid / i_ready); the frame-end pixel
// yields a second result, the frame summary with hit count and centroid.
// For ordinary pixels, a pixel can be accepted every cycle while the output
// register is free or being taken in the same cycle, and the registered mask
// result appears in the cycle after the transfer.
// A frame-end pixel occupies the block until the summary is loaded: per mean,
// a launch, the divider steps, a rounding step and a hand-off, once for the
// column mean and once for the row mean, then the summary is loaded once the
// output register is free; input ready stays low meanwhile.
// If the receiver stalls, the result waits in the output register and no
// further pixel is accepted until it has been taken.
// Reset (synchronous, active low) restores the register defaults, clears the
// frame counters and empties the output register.
// ----------------------------------------------------------------------------
module color_window_mask_centroid_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [cwmc_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [cwmc_pkg::DATA_W-1:0]   i_cfg_data,
    // Pixel input channel.
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cwmc_pkg::CH_W-1:0]     i_red,
    input  logic [cwmc_pkg::CH_W-1:0]     i_green,
    input  logic [cwmc_pkg::CH_W-1:0]     i_blue,
    input  logic [cwmc_pkg::CH_W-1:0]     i_ref_red,
    input  logic [cwmc_pkg::CH_W-1:0]     i_ref_green,
    input  logic [cwmc_pkg::CH_W-1:0]     i_ref_blue,
    input  logic                          i_frame_end,
    // Result output channel.
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_is_summary,
    output logic                          o_mask,
    output logic [cwmc_pkg::HIT_W-1:0]    o_hit_count,
    output logic [cwmc_pkg::CENT_W-1:0]   o_centroid_x,
    output logic [cwmc_pkg::CENT_W-1:0]   o_centroid_y,
    output logic                          o_centroid_valid,
    output logic                          o_last_result
);
    import cwmc_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int LW = (XW + 1 > LINE_W) ? XW + 1 : LINE_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STARTX = 3'd1;
    localparam logic [2:0] S_DIVX   = 3'd2;
    localparam logic [2:0] S_STARTY = 3'd3;
    localparam logic [2:0] S_DIVY   = 3'd4;
    localparam logic [2:0] S_SUM    = 3'd5;

    // Configuration registers.
    t_window_cfg       r_window;
    logic [LINE_W-1:0] r_line_width;
    logic              r_diff_mode;

    // Frame state.
    logic [2:0]        r_state, n_state;
    logic [XW-1:0]     r_col, n_col;
    logic [YW-1:0]     r_row, n_row;
    logic [HIT_W-1:0]  r_hits, n_hits;
    logic [SUM_W-1:0]  r_col_sum, n_col_sum;
    logic [SUM_W-1:0]  r_row_sum, n_row_sum;
    logic [CENT_W-1:0] r_cx, n_cx;

    // Output register.
    logic              r_o_valid, n_o_valid;
    logic              r_is_summary, n_is_summary;
    logic              r_mask, n_mask;
    logic [HIT_W-1:0]  r_hit_count, n_hit_count;
    logic [CENT_W-1:0] r_cent_x, n_cent_x;
    logic [CENT_W-1:0] r_cent_y, n_cent_y;
    logic              r_cent_valid, n_cent_valid;
    logic              r_last, n_last;

    logic              hit;
    logic              in_xfer;
    logic              out_xfer;
    logic              out_free;
    logic [LW-1:0]     eff_width;
    logic [LW-1:0]     col_next;
    logic              col_wrap;
    logic [YW:0]       row_next;
    logic [SUM_W:0]    col_sum_add;
    logic [SUM_W:0]    row_sum_add;
    logic              no_hits;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    // Pixel classification.
    cwmc_pixel u_pixel (
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_ref_red   (i_ref_red),
        .i_ref_green (i_ref_green),
        .i_ref_blue  (i_ref_blue),
        .i_diff_mode (r_diff_mode),
        .i_window    (r_window),
        .o_hit       (hit)
    );

    // Shared divider for both centroid means.
    cwmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_o_valid && i_ready;
    assign no_hits  = (r_hits == '0);

    // Divider launch: column sum first, then row sum, both over the hit count.
    assign div_req.start    = r_state inside {S_STARTX, S_STARTY};
    assign div_req.dividend = (r_state == S_STARTY) ? r_row_sum : r_col_sum;
    assign div_req.divisor  = r_hits;

    // Raster position: an out-of-range line width is clamped to 1..MAX_WIDTH.
    always_comb begin
        eff_width = LW'(r_line_width);
        if (eff_width == '0) begin
            eff_width = LW'(1);
        end else if (eff_width > LW'(MAX_WIDTH)) begin
            eff_width = LW'(MAX_WIDTH);
        end
    end
    assign col_next = LW'(r_col) + LW'(1);
    assign col_wrap = col_next >= eff_width;
    assign row_next = {1'b0, r_row} + (YW+1)'(1);

    // Saturating sums of hit positions.
    assign col_sum_add = {1'b0, r_col_sum} + (SUM_W+1)'(r_col);
    assign row_sum_add = {1'b0, r_row_sum} + (SUM_W+1)'(r_row);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window.red_min   <= '0;
            r_window.red_max   <= FULL_8;
            r_window.green_min <= '0;
            r_window.green_max <= FULL_8;
            r_window.blue_min  <= '0;
            r_window.blue_max  <= FULL_8;
            r_line_width       <= LINE_W_RESET;
            r_diff_mode        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RED_MIN:   r_window.red_min   <= i_cfg_data[CH_W-1:0];
                REG_RED_MAX:   r_window.red_max   <= i_cfg_data[CH_W-1:0];
                REG_GREEN_MIN: r_window.green_min <= i_cfg_data[CH_W-1:0];
                REG_GREEN_MAX: r_window.green_max <= i_cfg_data[CH_W-1:0];
                REG_BLUE_MIN:  r_window.blue_min  <= i_cfg_data[CH_W-1:0];
                REG_BLUE_MAX:  r_window.blue_max  <= i_cfg_data[CH_W-1:0];
                REG_LINE_W:    r_line_width       <= i_cfg_data[LINE_W-1:0];
                REG_DIFF_MODE: r_diff_mode        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer, frame accumulation and output register loading.
    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_hits       = r_hits;
        n_col_sum    = r_col_sum;
        n_row_sum    = r_row_sum;
        n_cx         = r_cx;
        n_o_valid    = out_xfer ? 1'b0 : r_o_valid;
        n_is_summary = r_is_summary;
        n_mask       = r_mask;
        n_hit_count  = r_hit_count;
        n_cent_x     = r_cent_x;
        n_cent_y     = r_cent_y;
        n_cent_valid = r_cent_valid;
        n_last       = r_last;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    // Accumulate the hit at the current position.
                    if (hit) begin
                        n_hits    = (r_hits == HIT_LIMIT) ? r_hits : r_hits + 1'b1;
                        n_col_sum = col_sum_add[SUM_W] ? SUM_LIMIT : col_sum_add[SUM_W-1:0];
                        n_row_sum = row_sum_add[SUM_W] ? SUM_LIMIT : row_sum_add[SUM_W-1:0];
                    end
                    // Advance the raster position; the row saturates at the bottom.
                    if (col_wrap) begin
                        n_col = '0;
                        if (row_next < (YW+1)'(MAX_HEIGHT)) begin
                            n_row = row_next[YW-1:0];
                        end
                    end else begin
                        n_col = col_next[XW-1:0];
                    end
                    // Mask result.
                    n_o_valid    = 1'b1;
                    n_is_summary = 1'b0;
                    n_mask       = hit;
                    n_hit_count  = '0;
                    n_cent_x     = '0;
                    n_cent_y     = '0;
                    n_cent_valid = 1'b0;
                    n_last       = !i_frame_end;
                    if (i_frame_end) begin
                        n_state = S_STARTX;
                    end
                end
            end
            S_STARTX: begin
                n_state = S_DIVX;
            end
            S_DIVX: begin
                if (div_rsp.done) begin
                    n_cx    = div_rsp.quotient;
                    n_state = S_STARTY;
                end
            end
            S_STARTY: begin
                n_state = S_DIVY;
            end
            S_DIVY: begin
                if (div_rsp.done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // Summary waits until the output register is free, then the frame clears.
                if (out_free) begin
                    n_o_valid    = 1'b1;
                    n_is_summary = 1'b1;
                    n_mask       = 1'b0;
                    n_hit_count  = r_hits;
                    n_cent_x     = no_hits ? '0 : r_cx;
                    n_cent_y     = no_hits ? '0 : div_rsp.quotient;
                    n_cent_valid = !no_hits;
                    n_last       = 1'b1;
                    n_col        = '0;
                    n_row        = '0;
                    n_hits       = '0;
                    n_col_sum    = '0;
                    n_row_sum    = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_hits    <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_hits    <= n_hits;
            r_col_sum <= n_col_sum;
            r_row_sum <= n_row_sum;
            r_o_valid <= n_o_valid;
        end
    end

    // Result payload and centroid holding register.
    always_ff @(posedge i_clk) begin
        r_cx         <= n_cx;
        r_is_summary <= n_is_summary;
        r_mask       <= n_mask;
        r_hit_count  <= n_hit_count;
        r_cent_x     <= n_cent_x;
        r_cent_y     <= n_cent_y;
        r_cent_valid <= n_cent_valid;
        r_last       <= n_last;
    end

    assign o_valid          = r_o_valid;
    assign o_is_summary     = r_is_summary;
    assign o_mask           = r_mask;
    assign o_hit_count      = r_hit_count;
    assign o_centroid_x     = r_cent_x;
    assign o_centroid_y     = r_cent_y;
    assign o_centroid_valid = r_cent_valid;
    assign o_last_result    = r_last;

    `include "color_window_mask_centroid_top_defines.svh"

    // A frame-end transfer always starts the centroid sequence.
    `CWMC_ASSERT_NXT(a_fend_starts_div, i_clk, i_rst_n,
                     in_xfer && i_frame_end, r_state == S_STARTX)
    // Divider completions only arrive while the sequencer waits for them.
    `CWMC_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n,
                     div_rsp.done, r_state == S_DIVX || r_state == S_DIVY)
    // An empty frame reports a zero, invalid centroid.
    `CWMC_ASSERT_IMP(a_empty_summary, i_clk, i_rst_n,
                     r_o_valid && r_is_summary && r_hit_count == '0,
                     r_cent_x == '0 && r_cent_y == '0 && !r_cent_valid)

endmodule
